>>> rtl/b64sc_pkg.sv
package b64sc_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [6:0] CLASS_PAD  = 7'd64;
   localparam logic [6:0] CLASS_BAD  = 7'd65;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_CHAR  = 3'd1,
      ERR_BAD_PAD   = 3'd2,
      ERR_LENGTH    = 3'd3,
      ERR_TOO_LONG  = 3'd4,
      ERR_TOO_SHORT = 3'd5
   } err_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_MODE            = 1'b0,
      CSR_EXPECTED_LENGTH = 1'b1
   } csr_index_type;

   // One queued unit of work: up to four results; only the final one may
   // carry last or an error code.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      count_m1;
      logic            final_last;
      err_type         final_err;
   } job_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         r = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

   function automatic logic [6:0] char_class(input logic [7:0] ch);
      logic [6:0] r;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r = 7'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         r = 7'(ch - 8'h61 + 8'd26);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         r = 7'(ch - 8'h30 + 8'd52);
      end else if (ch == 8'h2B) begin
         r = 7'd62;
      end else if (ch == 8'h2F) begin
         r = 7'd63;
      end else if (ch == PAD_CHAR) begin
         r = CLASS_PAD;
      end else begin
         r = CLASS_BAD;
      end
      return r;
   endfunction

endpackage

>>> rtl/b64sc_req_if.sv
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/b64sc_rsp_if.sv
interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [2:0] error_code;

   modport source (output valid, output out_byte, output out_last, output error_code,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input error_code,
                 output ready);
endinterface

>>> rtl/b64sc_front.sv
module b64sc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [23:0]       csr_wdata,
   input  logic              queue_full,
   output logic              push,
   output b64sc_pkg::job_type push_job
);
   import b64sc_pkg::*;

   logic        mode_ff, mode_in;
   logic [23:0] expected_length_ff, expected_length_in;
   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_position_ff, group_position_in;
   logic [1:0]  pad_count_ff, pad_count_in;
   logic        padding_seen_ff, padding_seen_in;
   logic [23:0] bytes_produced_ff, bytes_produced_in;
   logic        discarding_ff, discarding_in;

   logic        accept;
   logic [6:0]  cls;
   logic [1:0]  pos_enc;
   logic [23:0] enc_bits;
   logic [23:0] dec_bits;
   logic [23:0] bits_new;
   logic [1:0]  pad_new;
   logic [1:0]  nbytes;
   logic [24:0] sum;
   logic        short_end;
   logic        dfail;
   err_type     derr;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in            = mode_ff;
      expected_length_in = expected_length_ff;
      group_bits_in      = group_bits_ff;
      group_position_in  = group_position_ff;
      pad_count_in       = pad_count_ff;
      padding_seen_in    = padding_seen_ff;
      bytes_produced_in  = bytes_produced_ff;
      discarding_in      = discarding_ff;
      push               = 1'b0;
      push_job           = '0;
      dfail              = 1'b0;
      derr               = ERR_NONE;
      bits_new           = group_bits_ff;
      pad_new            = pad_count_ff;
      nbytes             = 2'd0;
      sum                = '0;
      short_end          = 1'b0;

      cls     = char_class(in_byte);
      pos_enc = (group_position_ff == 2'd3) ? 2'd2 : group_position_ff;

      case (pos_enc)
         2'd0:    enc_bits = group_bits_ff | {in_byte, 16'h0000};
         2'd1:    enc_bits = group_bits_ff | {8'h00, in_byte, 8'h00};
         default: enc_bits = group_bits_ff | {16'h0000, in_byte};
      endcase

      case (group_position_ff)
         2'd0:    dec_bits = group_bits_ff | {cls[5:0], 18'h0};
         2'd1:    dec_bits = group_bits_ff | {6'h0, cls[5:0], 12'h0};
         2'd2:    dec_bits = group_bits_ff | {12'h0, cls[5:0], 6'h0};
         default: dec_bits = group_bits_ff | {18'h0, cls[5:0]};
      endcase

      if (csr_write_en) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in           = csr_wdata[0];
               group_bits_in     = '0;
               group_position_in = '0;
               pad_count_in      = '0;
               padding_seen_in   = 1'b0;
               bytes_produced_in = '0;
               discarding_in     = 1'b0;
            end
            CSR_EXPECTED_LENGTH: expected_length_in = csr_wdata;
            default: ;
         endcase
      end else if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            if (pos_enc == 2'd2 || in_last) begin
               // flush the group, padding what the partial group lacks
               push                = 1'b1;
               push_job.data[0]    = enc_char(enc_bits[23:18]);
               push_job.data[1]    = enc_char(enc_bits[17:12]);
               push_job.data[2]    = (pos_enc != 2'd0) ? enc_char(enc_bits[11:6]) : PAD_CHAR;
               push_job.data[3]    = (pos_enc == 2'd2) ? enc_char(enc_bits[5:0]) : PAD_CHAR;
               push_job.count_m1   = 2'd3;
               push_job.final_last = in_last;
               push_job.final_err  = ERR_NONE;
               group_bits_in       = '0;
               group_position_in   = '0;
               if (in_last) begin
                  pad_count_in      = '0;
                  padding_seen_in   = 1'b0;
                  bytes_produced_in = '0;
                  discarding_in     = 1'b0;
               end
            end else begin
               group_bits_in     = enc_bits;
               group_position_in = pos_enc + 2'd1;
            end
         end else if (discarding_ff) begin
            // drop everything up to the last item of the message
            if (in_last) begin
               discarding_in = 1'b0;
            end
         end else begin
            if (in_last && group_position_ff != 2'd3) begin
               dfail = 1'b1;
               derr  = ERR_LENGTH;
            end else if (padding_seen_ff) begin
               dfail = 1'b1;
               derr  = ERR_BAD_PAD;
            end else if (cls == CLASS_BAD) begin
               dfail = 1'b1;
               derr  = ERR_BAD_CHAR;
            end else if (cls == CLASS_PAD) begin
               if (group_position_ff < 2'd2) begin
                  dfail = 1'b1;
                  derr  = ERR_BAD_PAD;
               end else begin
                  pad_new = pad_count_ff + 2'd1;
               end
            end else if (pad_count_ff != 2'd0) begin
               dfail = 1'b1;
               derr  = ERR_BAD_PAD;
            end else begin
               bits_new = dec_bits;
            end

            if (!dfail) begin
               if (group_position_ff != 2'd3) begin
                  group_bits_in     = bits_new;
                  group_position_in = group_position_ff + 2'd1;
                  pad_count_in      = pad_new;
               end else begin
                  nbytes = 2'd3 - pad_new;
                  sum    = {1'b0, bytes_produced_ff} + {23'h0, nbytes};
                  if (sum > {1'b0, expected_length_ff}) begin
                     dfail = 1'b1;
                     derr  = ERR_TOO_LONG;
                  end else begin
                     short_end           = in_last && (sum[23:0] != expected_length_ff);
                     push                = 1'b1;
                     push_job.data[0]    = bits_new[23:16];
                     push_job.data[1]    = (nbytes > 2'd1) ? bits_new[15:8] : 8'h00;
                     push_job.data[2]    = (nbytes > 2'd2) ? bits_new[7:0] : 8'h00;
                     push_job.data[3]    = 8'h00;
                     // a short message gets its error result behind the bytes
                     push_job.count_m1   = short_end ? nbytes : nbytes - 2'd1;
                     push_job.final_last = short_end ? 1'b1 : in_last;
                     push_job.final_err  = short_end ? ERR_TOO_SHORT : ERR_NONE;
                     group_bits_in       = '0;
                     group_position_in   = '0;
                     pad_count_in        = '0;
                     padding_seen_in     = (pad_new != 2'd0);
                     bytes_produced_in   = sum[23:0];
                     if (in_last) begin
                        padding_seen_in   = 1'b0;
                        bytes_produced_in = '0;
                        discarding_in     = 1'b0;
                     end
                  end
               end
            end

            if (dfail) begin
               push                = 1'b1;
               push_job            = '0;
               push_job.count_m1   = 2'd0;
               push_job.final_last = 1'b1;
               push_job.final_err  = derr;
               group_bits_in       = '0;
               group_position_in   = '0;
               pad_count_in        = '0;
               padding_seen_in     = 1'b0;
               bytes_produced_in   = '0;
               discarding_in       = !in_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_ENCODE;
         expected_length_ff <= '0;
         group_bits_ff      <= '0;
         group_position_ff  <= '0;
         pad_count_ff       <= '0;
         padding_seen_ff    <= 1'b0;
         bytes_produced_ff  <= '0;
         discarding_ff      <= 1'b0;
      end else begin
         mode_ff            <= mode_in;
         expected_length_ff <= expected_length_in;
         group_bits_ff      <= group_bits_in;
         group_position_ff  <= group_position_in;
         pad_count_ff       <= pad_count_in;
         padding_seen_ff    <= padding_seen_in;
         bytes_produced_ff  <= bytes_produced_in;
         discarding_ff      <= discarding_in;
      end
   end

endmodule

>>> rtl/b64sc_queue.sv
module b64sc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64sc_pkg::job_type push_job,
   input  logic              pop,
   output b64sc_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);
   import b64sc_pkg::*;

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("job popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");
`endif

endmodule

>>> rtl/b64sc_back.sv
module b64sc_back (
   input  logic              clock,
   input  logic              reset,
   input  b64sc_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        out_byte,
   output logic              out_last,
   output logic [2:0]        error_code
);
   import b64sc_pkg::*;

   logic [1:0] item_idx_ff, item_idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [2:0] err_ff;
   logic       load;
   logic       is_final;

   assign load     = !queue_empty && (!valid_ff || rsp_ready);
   assign is_final = (item_idx_ff == head_job.count_m1);
   assign pop      = load && is_final;

   always_comb begin
      item_idx_in = item_idx_ff;
      valid_in    = valid_ff;
      if (load) begin
         valid_in    = 1'b1;
         item_idx_in = is_final ? 2'd0 : item_idx_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_job.data[item_idx_ff];
         last_ff <= is_final && head_job.final_last;
         err_ff  <= is_final ? head_job.final_err : ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         item_idx_ff <= item_idx_in;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_last   = last_ff;
   assign error_code = err_ff;

endmodule

>>> rtl/base64_stream_codec.sv
// Streaming base64 codec, standard alphabet with '=' padding. Set mode (0
// encode, 1 decode) and, for decoding, expected_length while no message is in
// flight; writing mode drops any partial message. Encoding turns each group of
// three bytes into four characters and pads the group cut short by in_last.
// Decoding turns four characters into up to three bytes and reports a bad
// character, misplaced padding, a length that is not a multiple of four, or a
// byte count above or below expected_length as one result with out_byte 0,
// out_last 1 and the error code; the rest of that message up to in_last is
// dropped without results. A request is taken in any cycle in which the
// four-entry job queue between the classifying front end and the output
// sequencer has room, so requests stream back to back; results leave at one
// per cycle while the receiver takes them, through a registered output, which
// limits sustained encoding, as three bytes give four characters. Each group
// is held in the job queue, then its results in the output register.
module base64_stream_codec (
   input  logic        clock,
   input  logic        reset,
   b64sc_req_if.sink   req_ch,
   b64sc_rsp_if.source rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import b64sc_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    pop;
   logic    queue_empty;
   logic    queue_full;

   // classify requests and build whole groups of results
   b64sc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .in_byte      (req_ch.in_byte),
      .in_last      (req_ch.in_last),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   // hold finished groups so either side can stall alone
   b64sc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // advance through each group one result per cycle while the receiver takes them
   b64sc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .out_byte    (rsp_ch.out_byte),
      .out_last    (rsp_ch.out_last),
      .error_code  (rsp_ch.error_code)
   );

endmodule

>>> dv/tb_base64_stream_codec.sv
`timescale 1ns / 100ps

module tb_base64_stream_codec;
   import b64sc_pkg::*;

   // Timing and pacing
   localparam int          IDLE_PCT    = 14;      // chance in a hundred that a side idles
   localparam int          HOLD_CYCLES = 150;     // long receiver hold-off, once per run
   localparam int          PAUSE       = 8;       // settle time before a register write
   localparam int          DRAIN_LIMIT = 20000;   // per phase, before leftovers are flagged
   localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog for the whole run

   localparam logic [8*64-1:0] B64_SYMS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } b64_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      err_type    err;
   } b64_rsp_type;

   // Ways of spoiling a well-formed base64 message
   typedef enum int {
      FLAW_NONE,
      FLAW_BYTE,
      FLAW_SHORT,
      FLAW_PAD
   } flaw_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [23:0]   csr_wdata;

   b64sc_req_if req_ch ();
   b64sc_rsp_if rsp_ch ();

   base64_stream_codec dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // Requests waiting for the driver, and codec output still owed by the block
   b64_req_type stream_in_q[$];
   b64_rsp_type codec_out_q[$];

   int          fail_cnt  = 0;
   int unsigned cycle_cnt = 0;
   logic        calm        = 1'b0;  // both sides stop idling while set
   logic        hold_wanted = 1'b0;  // ask the receiver for its long hold-off
   int          hold_left   = 0;
   logic        hold_done   = 1'b0;

   // Shadow of the codec: configuration and stream state
   mode_type    cur_mode;
   logic [23:0] want_len;
   logic [23:0] grp_bits;
   logic [1:0]  grp_pos;
   logic [1:0]  pad_cnt;
   logic        pad_seen;
   logic [23:0] produced;
   logic        skipping;

   function automatic logic [7:0] sym_of(input logic [5:0] v);
      return B64_SYMS[8 * (63 - int'(v)) +: 8];
   endfunction

   function automatic void clear_stream();
      grp_bits = '0;
      grp_pos  = '0;
      pad_cnt  = '0;
      pad_seen = 1'b0;
      produced = '0;
      skipping = 1'b0;
   endfunction

   function automatic void emit(input logic [7:0] ch, input logic fin, input err_type e);
      codec_out_q.push_back('{ch, fin, e});
   endfunction

   // One error result ends the message; drop the rest of it unless this was its last request
   function automatic void fault(input err_type e, input logic fin);
      emit(8'h00, 1'b1, e);
      clear_stream();
      skipping = !fin;
   endfunction

   // Work out the codec output owed for one accepted request
   function automatic void codec_step(input logic [7:0] b, input logic fin);
      int         chars;
      int         nbytes;
      logic [6:0] cls;
      logic       short_end;
      if (cur_mode == MODE_ENCODE) begin
         grp_bits = grp_bits | (24'(b) << (8 * (2 - int'(grp_pos))));
         if (grp_pos < 2'd2 && !fin) begin
            grp_pos = grp_pos + 2'd1;
            return;
         end
         // a short group gives one character per byte plus one, then '=' fill
         chars = int'(grp_pos) + 2;
         for (int k = 0; k < 4; k++)
            emit((k < chars) ? sym_of(grp_bits[18 - 6 * k +: 6]) : PAD_CHAR,
                 fin && k == 3, ERR_NONE);
         clear_stream();
         return;
      end
      if (skipping) begin
         if (fin) clear_stream();
         return;
      end
      // precedence: length, character after a padded group, bad character, padding misuse
      if (fin && grp_pos != 2'd3) begin
         fault(ERR_LENGTH, fin);
         return;
      end
      if (pad_seen) begin
         fault(ERR_BAD_PAD, fin);
         return;
      end
      cls = (b == PAD_CHAR) ? CLASS_PAD : CLASS_BAD;
      for (int i = 0; i < 64; i++)
         if (sym_of(6'(i)) == b) cls = 7'(i);
      if (cls == CLASS_BAD) begin
         fault(ERR_BAD_CHAR, fin);
         return;
      end
      if (cls == CLASS_PAD) begin
         if (grp_pos < 2'd2) begin
            fault(ERR_BAD_PAD, fin);
            return;
         end
         pad_cnt = pad_cnt + 2'd1;
      end else begin
         if (pad_cnt != 2'd0) begin
            fault(ERR_BAD_PAD, fin);
            return;
         end
         grp_bits = grp_bits | (24'(cls[5:0]) << (6 * (3 - int'(grp_pos))));
      end
      if (grp_pos != 2'd3) begin
         grp_pos = grp_pos + 2'd1;
         return;
      end
      nbytes = 3 - int'(pad_cnt);
      // a group that overshoots the length gives the error alone, none of its bytes
      if (int'(produced) + nbytes > int'(want_len)) begin
         fault(ERR_TOO_LONG, fin);
         return;
      end
      produced  = produced + 24'(nbytes);
      short_end = fin && (produced < want_len);
      for (int j = 0; j < nbytes; j++)
         emit(grp_bits[16 - 8 * j +: 8], fin && !short_end && j == nbytes - 1, ERR_NONE);
      if (pad_cnt != 2'd0) pad_seen = 1'b1;
      grp_bits = '0;
      grp_pos  = '0;
      pad_cnt  = '0;
      // a message that ends short still delivers its bytes, then the error
      if (short_end) fault(ERR_TOO_SHORT, fin);
      else if (fin) clear_stream();
   endfunction

   // Driver: hold a request until taken, then feed the next one or idle
   always @(posedge clock) begin
      logic        taken;
      b64_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         taken = req_ch.valid && req_ch.ready;
         if (taken) codec_step(req_ch.in_byte, req_ch.in_last);
         if (!req_ch.valid || taken) begin
            if (stream_in_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = stream_in_q.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.in_byte <= nxt.data;
               req_ch.in_last <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result taken against the oldest one owed, then pick ready
   always @(posedge clock) begin
      b64_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (codec_out_q.size() == 0) begin
               $error("result with nothing owed: out_byte %h out_last %b error_code %0d",
                      rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.error_code);
               fail_cnt++;
            end else begin
               want = codec_out_q.pop_front();
               if (rsp_ch.out_byte !== want.ch) begin
                  $error("out_byte: expected %h, got %h", want.ch, rsp_ch.out_byte);
                  fail_cnt++;
               end
               if (rsp_ch.out_last !== want.last) begin
                  $error("out_last: expected %b, got %b", want.last, rsp_ch.out_last);
                  fail_cnt++;
               end
               if (rsp_ch.error_code !== want.err) begin
                  $error("error_code: expected %0d, got %0d", want.err, rsp_ch.error_code);
                  fail_cnt++;
               end
            end
         end
         // the long hold-off is counted here so the sender keeps pushing meanwhile
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Write a register; the block is idle, so update the shadow at once
   task automatic csr_put(input csr_index_type idx, input logic [23:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      if (idx == CSR_MODE) begin
         cur_mode = mode_type'(val[0]);
         clear_stream();
      end else begin
         want_len = val;
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic void offer(input logic [7:0] b, input logic fin);
      stream_in_q.push_back('{b, fin});
   endfunction

   // Queue a short text message, first character leftmost
   function automatic void offer_text(input logic [63:0] s, input int n);
      for (int i = 0; i < n; i++)
         offer(s[8 * (n - 1 - i) +: 8], i == n - 1);
   endfunction

   // Queue a base64 message of random symbols, padded at the tail, maybe spoilt
   function automatic void offer_b64(input int groups, input int pads, input flaw_type flaw);
      logic [7:0] txt[$];
      int         at;
      for (int i = 0; i < 4 * groups; i++)
         txt.push_back((i >= 4 * groups - pads) ? PAD_CHAR : sym_of(6'($urandom_range(63))));
      at = $urandom_range(txt.size() - 1);
      case (flaw)
         FLAW_BYTE: txt[at] = 8'($urandom_range(255));
         FLAW_PAD: txt[at] = PAD_CHAR;
         FLAW_SHORT: void'(txt.pop_back());
         default: ;
      endcase
      foreach (txt[i])
         offer(txt[i], i == txt.size() - 1);
   endfunction

   // Wait for the block to go quiet; flag and drop anything still owed
   task automatic drain();
      int n;
      n = 0;
      while ((stream_in_q.size() != 0 || req_ch.valid || codec_out_q.size() != 0)
             && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (PAUSE) @(negedge clock);
      if (stream_in_q.size() != 0 || req_ch.valid) begin
         $error("requests still waiting: %0d", stream_in_q.size());
         fail_cnt++;
      end
      if (codec_out_q.size() != 0) begin
         $error("results never arrived: %0d", codec_out_q.size());
         fail_cnt++;
         codec_out_q.delete();
      end
   endtask

   task automatic encode_phase(input int msgs);
      int len;
      csr_put(CSR_MODE, 24'(MODE_ENCODE));
      for (int m = 0; m < msgs; m++) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            offer(8'($urandom_range(255)), i == len - 1);
      end
      drain();
   endtask

   // Mostly well-formed messages, sized to a 1..36 length register, the rest broken or noise
   task automatic decode_phase(input logic [23:0] len, input int msgs);
      int groups;
      int pads;
      int pick;
      int n;
      csr_put(CSR_EXPECTED_LENGTH, len);
      csr_put(CSR_MODE, 24'(MODE_DECODE));
      for (int m = 0; m < msgs; m++) begin
         if (len == 24'd0 || len > 24'd36) begin
            groups = $urandom_range(1, 3);
            pads   = $urandom_range(0, 2);
         end else begin
            groups = (int'(len) + 2) / 3;
            pads   = 3 * groups - int'(len);
         end
         pick = $urandom_range(99);
         if (pick < 60) begin
            offer_b64(groups, pads, FLAW_NONE);
         end else if (pick < 70) begin
            // one group too many or too few
            offer_b64(($urandom_range(1) != 0 && groups > 1) ? groups - 1 : groups + 1,
                      pads, FLAW_NONE);
         end else if (pick < 78) begin
            offer_b64(groups, pads, FLAW_BYTE);
         end else if (pick < 84) begin
            offer_b64(groups, pads, FLAW_SHORT);
         end else if (pick < 90) begin
            offer_b64(groups, pads, FLAW_PAD);
         end else begin
            n = $urandom_range(1, 9);
            for (int i = 0; i < n; i++)
               offer(8'($urandom_range(255)), i == n - 1);
         end
      end
      drain();
   endtask

   initial begin
      // Drive every input to a known value before the first edge
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_MODE;
      csr_wdata      = '0;
      cur_mode       = MODE_ENCODE;
      want_len       = '0;
      clear_stream();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Encode: lone zero byte padded twice, then a full group of ones and a one-byte tail
      csr_put(CSR_MODE, 24'(MODE_ENCODE));
      offer(8'h00, 1'b1);
      offer(8'hFF, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'h80, 1'b1);
      drain();

      // Decode error cases against a three-byte length
      csr_put(CSR_MODE, 24'(MODE_DECODE));
      csr_put(CSR_EXPECTED_LENGTH, 24'd3);
      offer_text("*A", 2);      // bad character, rest of the message dropped
      offer_text("=A", 2);      // padding in the first position
      offer_text("T", 1);       // length not a multiple of four
      offer_text("TW=u", 4);    // symbol after '=' in the same group
      offer_text("TQ==AA", 6);  // character after a padded group
      offer_text("TQ==", 4);    // two bytes short of the length
      drain();
      csr_put(CSR_EXPECTED_LENGTH, 24'd2);
      offer_text("TWFu", 4);    // group would overshoot the length
      drain();

      // Random phases; the first one also has the receiver back off for a long stretch
      hold_wanted = 1'b1;
      encode_phase(10);
      decode_phase(24'($urandom_range(1, 12)), 7);
      calm = 1'b1;
      encode_phase(8);
      calm = 1'b0;
      decode_phase(24'd0, 3);
      decode_phase(24'hFFFFFF, 3);
      decode_phase(24'($urandom_range(1, 6)), 8);

      if (fail_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
